// File: rtl/core/bedb_pkg.sv
// Shared types and constants for the band energy beat detector.
// No dependencies; bedb_ctrl, bedb_dp and the core import this package.
package bedb_pkg;

  // Frame and window sizing
  localparam int NUM_BINS   = 2048;
  localparam int BIN_W      = 11;
  localparam int MAX_WINDOW = 512;
  localparam int PTR_W      = 9;
  localparam int FILL_W     = 10;

  // Field and accumulator widths
  localparam int MAG_W   = 16;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 12;
  localparam int TOT_W   = 25;
  localparam int LIM_W   = 12;
  localparam int MULT_W  = 11;
  localparam int FLOOR_W = 8;
  localparam int WENT_W  = 9;
  localparam int PROD_W  = MULT_W + MAG_W;

  // Shared divider: one quotient bit per cycle over the widest dividend
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_ENTRY  = 3'd4;

  localparam logic [LIM_W-1:0]   RST_LOW_LIMIT  = 12'd0;
  localparam logic [LIM_W-1:0]   RST_HIGH_LIMIT = 12'd929;
  localparam logic [MULT_W-1:0]  RST_MULTIPLIER = 11'd384;
  localparam logic [FLOOR_W-1:0] RST_FLOOR      = 8'd0;
  localparam logic [WENT_W-1:0]  RST_WIN_ENTRY  = 9'd59;

  // Beat payloads
  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [MAG_W-1:0] band_mean;
    logic [MAG_W-1:0] window_average;
    logic             beat;
    logic             band_empty;
    logic [BIN_W-1:0] lowest_bin;
    logic [BIN_W-1:0] highest_bin;
  } out_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take one bin into the frame accumulators
    logic div_load;   // load divider operands
    logic div_sel;    // 0: band sum / count, 1: window total / fill
    logic div_step;   // one quotient bit
    logic mean_load;  // latch capped quotient as band mean
    logic ev_sub;     // drop oldest window entry
    logic insert;     // write band mean into the window
    logic avg_load;   // latch capped quotient (or zero) as window average
    logic mul;        // multiplier times average
    logic out_load;   // load output register, clear frame state
  } bedb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;      // no in-band bin this frame
    logic evict_need; // window full for the configured length
    logic fill_zero;  // window holds no means
    logic out_busy;   // output register still holds an untaken result
  } bedb_sts_t;

  localparam logic DIV_SEL_MEAN = 1'b0;
  localparam logic DIV_SEL_AVG  = 1'b1;

endpackage

// File: rtl/core/bedb_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bedb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bedb_ctrl.sv
// Sequencing controller: bin intake and the end-of-frame sequence.
// Depends on bedb_pkg.
module bedb_ctrl
  import bedb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_beat_t  in_data,
  output logic      in_ready,
  input  bedb_sts_t sts,
  output bedb_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRAME,
    S_DIV_MEAN,
    S_MEAN_LD,
    S_EV_CHECK,
    S_EV_SUB,
    S_INSERT,
    S_AVG_START,
    S_DIV_AVG,
    S_AVG_LD,
    S_MUL,
    S_LOAD
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_acc;
        if (in_acc && in_data.frame_last) begin
          state_nxt = S_FRAME;
        end
      end
      S_FRAME: begin
        if (sts.empty) begin
          state_nxt = S_AVG_START;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_SEL_MEAN;
          cnt_nxt      = DIV_CNT_W'(DIV_STEPS - 1);
          state_nxt    = S_DIV_MEAN;
        end
      end
      S_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MEAN_LD;
        end
      end
      S_MEAN_LD: begin
        cmd.mean_load = 1'b1;
        state_nxt     = S_EV_CHECK;
      end
      // oldest entry address is presented here; its data arrives next cycle
      S_EV_CHECK: begin
        state_nxt = sts.evict_need ? S_EV_SUB : S_INSERT;
      end
      S_EV_SUB: begin
        cmd.ev_sub = 1'b1;
        state_nxt  = S_EV_CHECK;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_AVG_START;
      end
      S_AVG_START: begin
        if (sts.fill_zero) begin
          state_nxt = S_AVG_LD;
        end else begin
          cmd.div_load = 1'b1;
          cmd.div_sel  = DIV_SEL_AVG;
          cnt_nxt      = DIV_CNT_W'(DIV_STEPS - 1);
          state_nxt    = S_DIV_AVG;
        end
      end
      S_DIV_AVG: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_AVG_LD;
        end
      end
      S_AVG_LD: begin
        cmd.avg_load = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/bedb_dp.sv
// Datapath: config registers, frame accumulators, shared divider, window
// store and total, beat compare and output register. Depends on bedb_pkg, bedb_ram.
module bedb_dp
  import bedb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  bedb_cmd_t             cmd,
  output bedb_sts_t             sts
);

  // Configuration registers
  logic [LIM_W-1:0]   low_lim_r;
  logic [LIM_W-1:0]   high_lim_r;
  logic [MULT_W-1:0]  mult_r;
  logic [FLOOR_W-1:0] floor_r;
  logic [WENT_W-1:0]  went_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_lim_r  <= RST_LOW_LIMIT;
      high_lim_r <= RST_HIGH_LIMIT;
      mult_r     <= RST_MULTIPLIER;
      floor_r    <= RST_FLOOR;
      went_r     <= RST_WIN_ENTRY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_LIMIT:  low_lim_r  <= cfg_wdata[LIM_W-1:0];
        REG_HIGH_LIMIT: high_lim_r <= cfg_wdata[LIM_W-1:0];
        REG_MULTIPLIER: mult_r     <= cfg_wdata[MULT_W-1:0];
        REG_FLOOR:      floor_r    <= cfg_wdata[FLOOR_W-1:0];
        REG_WIN_ENTRY:  went_r     <= cfg_wdata[WENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame accumulators
  logic [BIN_W-1:0] bin_r, bin_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIN_W-1:0] lo_r, lo_nxt;
  logic [BIN_W-1:0] hi_r, hi_nxt;
  logic             in_band;
  logic [SUM_W:0]   sum_ext;

  assign in_band = ({1'b0, bin_r} > low_lim_r) && ({1'b0, bin_r} < high_lim_r);
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(in_data.magnitude);

  always_comb begin
    bin_nxt = bin_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (cmd.out_load) begin
      bin_nxt = '0;
      sum_nxt = '0;
      cnt_nxt = '0;
      lo_nxt  = '1;
      hi_nxt  = '0;
    end else if (cmd.accept) begin
      if (in_band) begin
        sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (bin_r < lo_r) begin
          lo_nxt = bin_r;
        end
        if (bin_r > hi_r) begin
          hi_nxt = bin_r;
        end
      end
      // bin index holds on the last bin until the frame is cleared
      if (!in_data.frame_last) begin
        bin_nxt = (bin_r == BIN_W'(NUM_BINS - 1)) ? '0 : bin_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
      lo_r  <= '1;
      hi_r  <= '0;
    end else begin
      bin_r <= bin_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
    end
  end

  // Window pointer, fill and running total
  logic [PTR_W-1:0]  ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic [TOT_W-1:0]  tot_r;

  // Shared restoring divider, one quotient bit per step
  logic [SUM_W-1:0] dq_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W:0]   trial;
  logic             trial_ok;
  logic [MAG_W-1:0] quo_cap;

  assign trial    = {rem_r, dq_r[SUM_W-1]};
  assign trial_ok = (trial >= {1'b0, dvs_r});
  assign quo_cap  = (|dq_r[SUM_W-1:MAG_W]) ? '1 : dq_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= '0;
      if (cmd.div_sel == DIV_SEL_MEAN) begin
        dq_r  <= sum_r;
        dvs_r <= cnt_r;
      end else begin
        dq_r  <= SUM_W'(tot_r);
        dvs_r <= CNT_W'(fill_r);
      end
    end else if (cmd.div_step) begin
      rem_r <= trial_ok ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      dq_r  <= {dq_r[SUM_W-2:0], trial_ok};
    end
  end

  // Window of recent band means
  logic [FILL_W-1:0] win_len;
  logic [PTR_W-1:0]  old_addr;
  logic [MAG_W-1:0]  old_mean;
  logic [MAG_W-1:0]  mean_r;

  // zero entries acts as one, and the length never exceeds the store
  always_comb begin
    win_len = (went_r == '0) ? FILL_W'(1) : FILL_W'(went_r);
    if (win_len > FILL_W'(MAX_WINDOW)) begin
      win_len = FILL_W'(MAX_WINDOW);
    end
  end

  assign old_addr = ptr_r - fill_r[PTR_W-1:0];

  bedb_ram #(
    .WIDTH(MAG_W),
    .DEPTH(MAX_WINDOW)
  ) u_window (
    .clk  (clk),
    .we   (cmd.insert),
    .waddr(ptr_r),
    .wdata(mean_r),
    .raddr(old_addr),
    .rdata(old_mean)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      tot_r  <= '0;
    end else if (cmd.ev_sub) begin
      tot_r  <= tot_r - TOT_W'(old_mean);
      fill_r <= fill_r - 1'b1;
    end else if (cmd.insert) begin
      tot_r  <= tot_r + TOT_W'(mean_r);
      fill_r <= fill_r + 1'b1;
      ptr_r  <= ptr_r + 1'b1;
    end
  end

  // Mean, average and product
  logic [MAG_W-1:0]  avg_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean_r <= quo_cap;
    end
    if (cmd.avg_load) begin
      avg_r <= (fill_r == '0) ? '0 : quo_cap;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mult_r) * PROD_W'(avg_r);
    end
  end

  // Beat compare and output register
  logic      empty;
  logic      beat_hit;
  logic      out_valid_r;
  out_beat_t out_data_r;

  assign empty    = (cnt_r == '0);
  assign beat_hit = !empty
                  && ({mean_r, 8'd0} > prod_r[MAG_W+8-1:0])
                  && (prod_r[PROD_W-1:MAG_W+8] == '0)
                  && (mean_r > MAG_W'(floor_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.band_mean      <= empty ? '0 : mean_r;
      out_data_r.window_average <= avg_r;
      out_data_r.beat           <= beat_hit;
      out_data_r.band_empty     <= empty;
      out_data_r.lowest_bin     <= empty ? '0 : lo_r;
      out_data_r.highest_bin    <= empty ? '0 : hi_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.empty      = empty;
  assign sts.evict_need = (fill_r >= win_len);
  assign sts.fill_zero  = (fill_r == '0);
  assign sts.out_busy   = out_valid_r & ~out_ready;

endmodule

// File: rtl/core/band_energy_beat_detector_core.sv
// Band energy beat detector: takes one FFT magnitude bin per beat and, on
// the last bin of each frame, returns one result beat. Bins are taken one
// per cycle. After the last bin the block stops taking input for the
// end-of-frame sequence, set by the shared one-bit-per-cycle divider that
// is used twice (band mean, then window average) and by the window RAM's
// registered read, waited on for each old mean dropped from the window
// (usually one once the window is full). With no bin in the band the mean
// division and window update are skipped; the average division is also
// skipped when the window is empty. The sequence holds on its last step
// while the previous result still waits in the output register; otherwise
// a finished result waits there while the next frame's bins are taken.
// Depends on bedb_pkg, bedb_ctrl, bedb_dp, bedb_ram.
module band_energy_beat_detector_core
  import bedb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  bedb_cmd_t cmd;
  bedb_sts_t sts;

  // Sequencer
  bedb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_data (in_data),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Arithmetic and storage
  bedb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
